// ===== src/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/vsw_pkg.sv =====
// ----------------------------------------------------------------------------
// vsw_pkg: shared types and constants
// Widths, register indexes and the request format of the iterative unit.
// ----------------------------------------------------------------------------
package vsw_pkg;

  localparam int ELEM_W            = 16;
  localparam int SUM_W             = 40;
  localparam int CFG_W             = 7;
  localparam int CFG_IDX_W         = 8;
  localparam int CNT_W             = 6;
  localparam int MAX_VECTOR_LENGTH = 64;
  localparam int WINDOW_MAX        = 64;
  localparam int ITER_W            = 64;
  localparam int STEP_W            = 6;
  localparam int TOTAL_W           = 24;

  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_VECTORS = 8'd1;

  typedef enum logic {
    ITER_SQRT,
    ITER_DIV
  } iter_mode_t;

  // One request to the shared unit.
  // Root: acc holds the radicand, bits holds the first trial bit.
  // Divide: acc holds the starting remainder, bits the numerator to shift in.
  typedef struct packed {
    iter_mode_t          mode;
    logic [ITER_W:0]     acc;
    logic [ITER_W-1:0]   bits;
    logic [ITER_W-1:0]   divisor;
    logic [STEP_W-1:0]   steps;
  } iter_req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] dot;
    logic [SUM_W-1:0]        norm_a;
    logic [SUM_W-1:0]        norm_b;
    logic [SUM_W-1:0]        diff_sq;
  } sums_t;

endpackage

// ===== src/vector_similarity_window.sv =====
// Sequence: an element that does not close a vector only updates the sums; a closing
// element runs two roots, a multiply, a divide and a root before its result is
// registered, and a divide for the mean when it also closes the window; a zero norm
// skips both roots, the multiply and the divide, a saturated cosine skips the divide.
// Throughput: 1 request per cycle within a vector; input is held off until the
// result is registered. Reset (rst_n low, synchronous) clears sums, counters, loads 8/20.
// ----------------------------------------------------------------------------
// vector_similarity_window: cosine similarity and Euclidean distance
// Accumulates element pairs, reports cosine and distance per vector and the
// mean cosine over a window of vectors.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vector_similarity_window import vsw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [ELEM_W-1:0] in_a_elem,
  input  logic signed [ELEM_W-1:0] in_b_elem,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [15:0]       out_cosine_out,
  output logic [15:0]              out_distance_out,
  output logic [CNT_W-1:0]         out_vector_index,
  output logic                     out_window_done,
  output logic signed [15:0]       out_window_mean,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQA_GO, S_SQA_W, S_SQB_GO, S_SQB_W, S_MUL, S_DIVC_GO,
    S_DIVC_W, S_DIST_GO, S_DIST_W, S_MEAN_GO, S_MEAN_W, S_OUT
  } state_t;

  state_t                    state_r;
  logic [CFG_W-1:0]          vlen_r;
  logic [CFG_W-1:0]          win_r;
  logic [CNT_W-1:0]          elem_cnt_r;
  logic [CNT_W-1:0]          vec_cnt_r;
  logic signed [TOTAL_W-1:0] total_r;
  logic [31:0]               sa_r;
  logic [31:0]               sb_r;
  logic [ITER_W-1:0]         d_r;
  logic signed [15:0]        cos_r;
  logic [15:0]               dist_r;
  logic signed [15:0]        mean_r;
  logic                      done_r;
  logic                      out_valid_r;
  logic signed [15:0]        out_cos_r;
  logic [15:0]               out_dist_r;
  logic [CNT_W-1:0]          out_idx_r;
  logic                      out_done_r;
  logic signed [15:0]        out_mean_r;

  logic [CFG_W-1:0]          len_eff;
  logic [CFG_W-1:0]          win_eff;
  logic                      in_fire;
  logic                      elem_last;
  logic                      acc_clr;
  sums_t                     sums;
  logic                      iter_start;
  iter_req_t                 iter_req;
  logic                      iter_busy;
  logic [ITER_W-1:0]         iter_res;
  logic                      dot_neg;
  logic [SUM_W-1:0]          dot_mag;
  logic [ITER_W:0]           t_num;
  logic                      tot_neg;
  logic [TOTAL_W-1:0]        tot_mag;
  logic [15:0]               q16;

  // clamp the configured counts to their usable ranges
  always_comb begin
    if (vlen_r == '0) begin
      len_eff = CFG_W'(1);
    end else if (vlen_r > CFG_W'(MAX_VECTOR_LENGTH)) begin
      len_eff = CFG_W'(MAX_VECTOR_LENGTH);
    end else begin
      len_eff = vlen_r;
    end
    if (win_r == '0) begin
      win_eff = CFG_W'(1);
    end else if (win_r > CFG_W'(WINDOW_MAX)) begin
      win_eff = CFG_W'(WINDOW_MAX);
    end else begin
      win_eff = win_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign elem_last = (CFG_W'(elem_cnt_r) + CFG_W'(1)) >= len_eff;
  assign cfg_ready = 1'b1;
  assign acc_clr   = (state_r == S_OUT) && (!out_valid_r || out_ready);

  vsw_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .add_en (in_fire),
    .clr    (acc_clr),
    .a_elem (in_a_elem),
    .b_elem (in_b_elem),
    .sums   (sums)
  );

  // operand magnitudes for the divides
  assign dot_neg = sums.dot[SUM_W-1];
  assign dot_mag = dot_neg ? SUM_W'(-sums.dot) : SUM_W'(sums.dot);
  assign t_num   = (ITER_W+1)'(dot_mag) << 26;
  assign tot_neg = total_r[TOTAL_W-1];
  assign tot_mag = tot_neg ? TOTAL_W'(-total_r) : TOTAL_W'(total_r);
  assign q16     = iter_res[15:0];

  // build the request for the shared unit
  always_comb begin
    iter_start       = 1'b0;
    iter_req.mode    = ITER_SQRT;
    iter_req.acc     = '0;
    iter_req.bits    = ITER_W'(1) << 62;
    iter_req.divisor = d_r;
    iter_req.steps   = STEP_W'(32);
    unique case (state_r)
      S_SQA_GO: begin
        iter_start   = (sums.norm_a != '0) && (sums.norm_b != '0);
        iter_req.acc = (ITER_W+1)'(sums.norm_a) << 26;
      end
      S_SQB_GO: begin
        iter_start   = 1'b1;
        iter_req.acc = (ITER_W+1)'(sums.norm_b) << 26;
      end
      S_DIVC_GO: begin
        iter_start     = t_num < {1'b0, d_r};
        iter_req.mode  = ITER_DIV;
        iter_req.acc   = t_num;
        iter_req.bits  = '0;
        iter_req.steps = STEP_W'(15);
      end
      S_DIST_GO: begin
        iter_start     = 1'b1;
        iter_req.acc   = (ITER_W+1)'(sums.diff_sq >> 8);
        iter_req.bits  = ITER_W'(1) << 30;
        iter_req.steps = STEP_W'(16);
      end
      S_MEAN_GO: begin
        iter_start       = 1'b1;
        iter_req.mode    = ITER_DIV;
        iter_req.bits    = {tot_mag[21:0], 42'b0};
        iter_req.divisor = ITER_W'(win_eff);
        iter_req.steps   = STEP_W'(22);
      end
      default: begin
        iter_start = 1'b0;
      end
    endcase
  end

  vsw_iter u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (iter_start),
    .req    (iter_req),
    .busy   (iter_busy),
    .result (iter_res)
  );

  // sequencer, counters, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vlen_r      <= CFG_W'(8);
      win_r       <= CFG_W'(20);
      elem_cnt_r  <= '0;
      vec_cnt_r   <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_VECTOR_LENGTH) begin
          vlen_r <= cfg_data;
        end else if (cfg_index == REG_WINDOW_VECTORS) begin
          win_r <= cfg_data;
        end
      end
      // drop the result once taken, unless a new one is loaded this cycle
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (elem_last) begin
              elem_cnt_r <= '0;
              state_r    <= S_SQA_GO;
            end else begin
              elem_cnt_r <= elem_cnt_r + 1'b1;
            end
          end
        end
        S_SQA_GO: begin
          if (iter_start) begin
            state_r <= S_SQA_W;
          end else begin
            cos_r   <= '0;
            state_r <= S_DIST_GO;
          end
        end
        S_SQA_W: begin
          if (!iter_busy) begin
            sa_r    <= iter_res[31:0];
            state_r <= S_SQB_GO;
          end
        end
        S_SQB_GO: state_r <= S_SQB_W;
        S_SQB_W: begin
          if (!iter_busy) begin
            sb_r    <= iter_res[31:0];
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          d_r     <= sa_r * sb_r;
          state_r <= S_DIVC_GO;
        end
        S_DIVC_GO: begin
          if (iter_start) begin
            state_r <= S_DIVC_W;
          end else begin
            // quotient of one or more: saturate
            cos_r   <= dot_neg ? 16'sh8000 : 16'sh7fff;
            state_r <= S_DIST_GO;
          end
        end
        S_DIVC_W: begin
          if (!iter_busy) begin
            cos_r   <= dot_neg ? -$signed({1'b0, iter_res[14:0]})
                               : $signed({1'b0, iter_res[14:0]});
            state_r <= S_DIST_GO;
          end
        end
        S_DIST_GO: state_r <= S_DIST_W;
        S_DIST_W: begin
          if (!iter_busy) begin
            dist_r  <= (iter_res[ITER_W-1:16] != '0) ? 16'hffff : iter_res[15:0];
            total_r <= total_r + TOTAL_W'(cos_r);
            done_r  <= (CFG_W'(vec_cnt_r) + CFG_W'(1)) >= win_eff;
            mean_r  <= '0;
            if ((CFG_W'(vec_cnt_r) + CFG_W'(1)) >= win_eff) begin
              state_r <= S_MEAN_GO;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_MEAN_GO: state_r <= S_MEAN_W;
        S_MEAN_W: begin
          if (!iter_busy) begin
            mean_r  <= tot_neg ? $signed(-q16) : $signed(q16);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_cos_r   <= cos_r;
            out_dist_r  <= dist_r;
            out_idx_r   <= vec_cnt_r;
            out_done_r  <= done_r;
            out_mean_r  <= mean_r;
            if (done_r) begin
              vec_cnt_r <= '0;
              total_r   <= '0;
            end else begin
              vec_cnt_r <= vec_cnt_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cosine_out   = out_cos_r;
  assign out_distance_out = out_dist_r;
  assign out_vector_index = out_idx_r;
  assign out_window_done  = out_done_r;
  assign out_window_mean  = out_mean_r;

  // an element that does not close a vector leaves the block ready
  `ASSERT_NEXT(a_mid_ready, clk, rst_n, in_fire && !elem_last, in_ready)
  // the mean is only reported on the result that closes a window
  `ASSERT_IMPL(a_mean_zero, clk, rst_n, out_valid && !out_window_done, out_window_mean == 16'sd0)
  // the shared unit is never left running while requests are taken
  `ASSERT_IMPL(a_iter_idle, clk, rst_n, state_r == S_IDLE, !iter_busy)

endmodule

// ===== src/vsw_accum.sv =====
// ----------------------------------------------------------------------------
// vsw_accum: element accumulator
// Adds a*b, a*a, b*b and (a-b)^2 of each request into four running sums.
// ----------------------------------------------------------------------------
module vsw_accum import vsw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     add_en,
  input  logic                     clr,
  input  logic signed [ELEM_W-1:0] a_elem,
  input  logic signed [ELEM_W-1:0] b_elem,
  output sums_t                    sums
);

  logic signed [2*ELEM_W-1:0] p_ab;
  logic signed [2*ELEM_W-1:0] p_aa;
  logic signed [2*ELEM_W-1:0] p_bb;
  logic signed [ELEM_W:0]     diff;
  logic signed [2*ELEM_W+1:0] p_dd;
  sums_t                      sums_r;

  // form the four products of this element pair
  assign p_ab = a_elem * b_elem;
  assign p_aa = a_elem * a_elem;
  assign p_bb = b_elem * b_elem;
  assign diff = (ELEM_W+1)'(a_elem) - (ELEM_W+1)'(b_elem);
  assign p_dd = diff * diff;

  // accumulate, or drop the sums once the vector has been reported
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      sums_r <= '0;
    end else if (add_en) begin
      sums_r.dot     <= sums_r.dot + SUM_W'(p_ab);
      sums_r.norm_a  <= sums_r.norm_a + SUM_W'($unsigned(p_aa));
      sums_r.norm_b  <= sums_r.norm_b + SUM_W'($unsigned(p_bb));
      sums_r.diff_sq <= sums_r.diff_sq + SUM_W'($unsigned(p_dd));
    end
  end

  assign sums = sums_r;

endmodule

// ===== src/vsw_iter.sv =====
// ----------------------------------------------------------------------------
// vsw_iter: shared root and divide unit
// One compare-and-subtract per cycle; restoring square root or division.
// ----------------------------------------------------------------------------
module vsw_iter import vsw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  iter_req_t         req,
  output logic              busy,
  output logic [ITER_W-1:0] result
);

  logic              busy_r;
  iter_mode_t        mode_r;
  logic [ITER_W:0]   acc_r;
  logic [ITER_W-1:0] aux_r;
  logic [ITER_W-1:0] bits_r;
  logic [ITER_W-1:0] div_r;
  logic [STEP_W-1:0] cnt_r;

  logic [ITER_W:0]   cand;
  logic [ITER_W:0]   trial;
  logic [ITER_W:0]   rem;
  logic              ge;

  // pick operands of the single compare/subtract
  always_comb begin
    unique case (mode_r)
      ITER_SQRT: begin
        cand  = acc_r;
        trial = {1'b0, aux_r} + {1'b0, bits_r};
      end
      ITER_DIV: begin
        cand  = {acc_r[ITER_W-1:0], bits_r[ITER_W-1]};
        trial = {1'b0, div_r};
      end
      default: begin
        cand  = acc_r;
        trial = {1'b0, div_r};
      end
    endcase
    ge  = cand >= trial;
    rem = ge ? cand - trial : cand;
  end

  // load a request or advance one step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= req.steps;
      mode_r <= req.mode;
      acc_r  <= req.acc;
      aux_r  <= '0;
      bits_r <= req.bits;
      div_r  <= req.divisor;
    end else if (busy_r) begin
      acc_r <= rem;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
      if (mode_r == ITER_SQRT) begin
        aux_r  <= ge ? (aux_r >> 1) + bits_r : aux_r >> 1;
        bits_r <= bits_r >> 2;
      end else begin
        aux_r  <= {aux_r[ITER_W-2:0], ge};
        bits_r <= bits_r << 1;
      end
    end
  end

  assign busy   = busy_r;
  assign result = aux_r;

endmodule

// ===== tb/tb_vector_similarity_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_similarity_window: self-checking testbench
// Drives element pairs and register writes into the similarity block.
// Every result is compared against a cycle-free model of the arithmetic.
// Directed checks cover extremes and zero norms; random phases then sweep
// vector and window lengths under bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_vector_similarity_window import vsw_pkg::*;;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE      = 200;
  localparam int RAND_ITEMS  = 1500;

  typedef struct {
    logic signed [15:0] cosine;
    logic [15:0]        distance;
    logic [CNT_W-1:0]   index;
    logic               done;
    logic signed [15:0] mean;
  } sim_result_t;

  typedef struct {
    logic signed [ELEM_W-1:0] a;
    logic signed [ELEM_W-1:0] b;
    bit                       typed;
    sim_result_t              want;
  } pair_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [ELEM_W-1:0] in_a_elem = '0;
  logic signed [ELEM_W-1:0] in_b_elem = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_cosine_out;
  logic [15:0] out_distance_out;
  logic [CNT_W-1:0] out_vector_index;
  logic out_window_done;
  logic signed [15:0] out_window_mean;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  vector_similarity_window dut (.*);

  // Model state
  logic [CFG_W-1:0]  m_len, m_win;
  int unsigned       m_elems, m_vecs;
  longint unsigned   m_dot, m_norm_a, m_norm_b, m_diff_sq;
  int                m_cos_total;

  sim_result_t expected_q[$];
  int  failures = 0;
  int  cycles = 0;
  bit  hold_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a run that has hung
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic int cosine_q15(longint unsigned dot, longint unsigned na,
                                    longint unsigned nb);
    bit neg;
    longint unsigned mag, sa, sb, d, t, q, r;
    neg = dot[63];
    mag = neg ? -dot : dot;
    if (na == 0 || nb == 0) return 0;
    sa = int_sqrt(na << 26);
    sb = int_sqrt(nb << 26);
    d = sa * sb;
    if (d == 0) return 0;
    t = mag << 26;
    q = t / d;
    r = t % d;
    if (q > 2) q = 2;
    for (int i = 0; i < 15; i++) begin
      r <<= 1;
      q <<= 1;
      if (r >= d) begin
        r -= d;
        q |= 1;
      end
    end
    if (neg) return (q >= 32768) ? -32768 : -int'(q);
    return (q > 32767) ? 32767 : int'(q);
  endfunction

  // Advance the model by one pair; return 1 with the result when a vector closes
  function automatic bit predict_pair(logic signed [ELEM_W-1:0] a,
                                      logic signed [ELEM_W-1:0] b,
                                      output sim_result_t res);
    longint sa, sb, df;
    int unsigned len, win;
    int cosv;
    longint unsigned dist_v;
    sa = a;
    sb = b;
    df = sa - sb;
    len = (m_len < 1) ? 1 : (m_len > MAX_VECTOR_LENGTH) ? MAX_VECTOR_LENGTH : m_len;
    win = (m_win < 1) ? 1 : (m_win > WINDOW_MAX) ? WINDOW_MAX : m_win;
    m_dot += longint'(sa * sb);
    m_norm_a += longint'(sa * sa);
    m_norm_b += longint'(sb * sb);
    m_diff_sq += longint'(df * df);
    if (m_elems + 1 < len) begin
      m_elems++;
      return 1'b0;
    end
    cosv = cosine_q15(m_dot, m_norm_a, m_norm_b);
    dist_v = int_sqrt(m_diff_sq >> 8);
    if (dist_v > 65535) dist_v = 65535;
    m_cos_total += cosv;
    res.cosine = cosv[15:0];
    res.distance = dist_v[15:0];
    res.index = m_vecs[CNT_W-1:0];
    res.done = (m_vecs + 1 >= win);
    res.mean = res.done ? 16'(m_cos_total / int'(win)) : 16'sd0;
    m_elems = 0;
    m_dot = 0;
    m_norm_a = 0;
    m_norm_b = 0;
    m_diff_sq = 0;
    if (res.done) begin
      m_vecs = 0;
      m_cos_total = 0;
    end else begin
      m_vecs++;
    end
    return 1'b1;
  endfunction

  // Write one register; the model follows only for known indexes
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_VECTOR_LENGTH) m_len = val;
    else if (idx == REG_WINDOW_VECTORS) m_win = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold the request until accepted, then log what it should produce
  task automatic send_pair(logic signed [ELEM_W-1:0] a, logic signed [ELEM_W-1:0] b,
                           bit typed, sim_result_t want);
    sim_result_t res;
    bit closes;
    in_valid <= 1'b1;
    in_a_elem <= a;
    in_b_elem <= b;
    do @(posedge clk); while (!in_ready);
    closes = predict_pair(a, b, res);
    if (closes) expected_q.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  // Drain the block, then leave time for trailing work before a write
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Output stall pattern, with one long hold-off
  always @(negedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else if (cycles % 3000 < 1000) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    wait (cycles == 5000);
    hold_off = 1'b1;
    repeat (3000) @(posedge clk);
    hold_off = 1'b0;
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    sim_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result cosine=%0d", out_cosine_out);
        failures++;
      end else begin
        e = expected_q.pop_front();
        if (out_cosine_out !== e.cosine) begin
          $error("cosine_out exp %0d got %0d", e.cosine, out_cosine_out);
          failures++;
        end
        if (out_distance_out !== e.distance) begin
          $error("distance_out exp %0d got %0d", e.distance, out_distance_out);
          failures++;
        end
        if (out_vector_index !== e.index) begin
          $error("vector_index exp %0d got %0d", e.index, out_vector_index);
          failures++;
        end
        if (out_window_done !== e.done) begin
          $error("window_done exp %0d got %0d", e.done, out_window_done);
          failures++;
        end
        if (out_window_mean !== e.mean) begin
          $error("window_mean exp %0d got %0d", e.mean, out_window_mean);
          failures++;
        end
      end
    end
  end

  initial begin
    pair_row_t rows[$];
    sim_result_t none;
    int sent, phase_items, burst, len_pick, win_pick;
    logic signed [ELEM_W-1:0] ra, rb;
    none = '{16'sd0, 16'd0, '0, 1'b0, 16'sd0};
    m_len = 7'd8;
    m_win = 7'd20;
    m_elems = 0;
    m_vecs = 0;
    m_dot = 0;
    m_norm_a = 0;
    m_norm_b = 0;
    m_diff_sq = 0;
    m_cos_total = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: one element per vector, one vector per window
    rows = '{
      '{16'sd0, 16'sd0, 1, '{16'sd0, 16'd0, 6'd0, 1'b1, 16'sd0}},
      '{16'sd16384, 16'sd16384, 1, '{16'sd32767, 16'd0, 6'd0, 1'b1, 16'sd32767}},
      '{16'sd16384, -16'sd16384, 1, '{-16'sd32768, 16'd2048, 6'd0, 1'b1, -16'sd32768}},
      '{-16'sd32768, 16'sd32767, 0, none},
      '{16'sd32767, -16'sd32768, 0, none},
      '{-16'sd32768, -16'sd32768, 0, none},
      '{16'sd32767, 16'sd32767, 0, none},
      '{16'sd0, 16'sd32767, 0, none},
      '{-16'sd1, 16'sd0, 0, none},
      '{16'sd1, 16'sd1, 0, none}
    };
    write_reg(REG_VECTOR_LENGTH, 7'd1);
    write_reg(REG_WINDOW_VECTORS, 7'd1);
    foreach (rows[i]) send_pair(rows[i].a, rows[i].b, rows[i].typed, rows[i].want);

    // Directed: full-length vectors of extremes over a short window
    wait_idle();
    write_reg(REG_VECTOR_LENGTH, 7'd64);
    write_reg(REG_WINDOW_VECTORS, 7'd2);
    for (int i = 0; i < 128; i++)
      send_pair((i % 2) ? -16'sd32768 : 16'sd32767, -16'sd32768, 0, none);

    // Random phases, most with short vectors
    sent = 0;
    burst = 0;
    while (sent < RAND_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: begin len_pick = 0; win_pick = 0; end
        1: begin len_pick = 127; win_pick = 127; end
        2: begin len_pick = 64; win_pick = 64; end
        3: begin len_pick = $urandom_range(1, 3); win_pick = 64; end
        default: begin
          len_pick = $urandom_range(1, 8);
          win_pick = $urandom_range(1, 12);
        end
      endcase
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_WINDOW_VECTORS + 1, 255)), CFG_W'($urandom));
      if ($urandom_range(0, 4) != 0) write_reg(REG_VECTOR_LENGTH, CFG_W'(len_pick));
      if ($urandom_range(0, 4) != 0) write_reg(REG_WINDOW_VECTORS, CFG_W'(win_pick));
      phase_items = (len_pick >= 64) ? $urandom_range(64, 200) : $urandom_range(20, 120);
      for (int i = 0; i < phase_items; i++) begin
        // Bursts of requests separated by idle gaps
        if (burst == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(0, 6)) @(negedge clk);
          burst = $urandom_range(1, 40);
        end
        case ($urandom_range(0, 7))
          0: begin ra = 16'sd0; rb = 16'($urandom); end
          1: begin ra = 16'($urandom); rb = ra; end
          2: begin ra = -16'sd32768; rb = 16'sd32767; end
          default: begin ra = 16'($urandom); rb = 16'($urandom); end
        endcase
        send_pair(ra, rb, 0, none);
        burst--;
        sent++;
      end
    end

    wait_idle();
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/vsw_pkg.sv
src/vsw_accum.sv
src/vsw_iter.sv
src/vector_similarity_window.sv
tb/tb_vector_similarity_window.sv
